/* sv/thc_pkg.sv */
// thc_pkg: types, opcodes and the fnv-1a byte mixer for the tick hash chain
// no dependencies; used by the front, the back and the top level
package thc_pkg;

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_HEADER  = 2'd1;
  localparam logic [1:0] OP_DATA    = 2'd2;
  localparam logic [1:0] OP_COMPARE = 2'd3;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  // one queued command: opcode, last mark and a single merged operand
  // (tick number, zero-extended data byte or the other run's hash)
  typedef struct packed {
    logic [1:0]  op;
    logic        last;
    logic [63:0] operand;
  } cmd_t;

  // h = (h ^ b) * 0x100000001b3 mod 2^64, written as shift-adds
  function automatic logic [63:0] mix_byte(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

/* sv/thc_if.sv */
// thc_if: valid/ready channel interfaces for items, results and the seed write
// depends on nothing; payload widths follow the work fields
interface thc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] tick_number;
  logic [7:0]  data_byte;
  logic        last;
  logic [63:0] other_hash;

  modport source (output valid, opcode, tick_number, data_byte, last, other_hash,
                  input ready);
  modport sink   (input valid, opcode, tick_number, data_byte, last, other_hash,
                  output ready);
endinterface

interface thc_out_if #(parameter int CNT_W = 9);
  logic             valid;
  logic             ready;
  logic [63:0]      running_hash;
  logic [63:0]      current_tick;
  logic [CNT_W-1:0] entries_stored;
  logic             history_overflow;
  logic             compare_done;
  logic             diverged;
  logic [63:0]      divergence_tick;

  modport source (output valid, running_hash, current_tick, entries_stored,
                  history_overflow, compare_done, diverged, divergence_tick,
                  input ready);
  modport sink   (input valid, running_hash, current_tick, entries_stored,
                  history_overflow, compare_done, diverged, divergence_tick,
                  output ready);
endinterface

interface thc_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

/* sv/thc_ram.sv */
// thc_ram: generic single-write, single-read ram with registered read data
// no dependencies
module thc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/thc_front.sv */
// thc_front: accepts items, classifies them into commands, two-entry queue
// depends on thc_pkg and thc_in_if
module thc_front (
  input  logic           clk,
  input  logic           rst,
  thc_in_if.sink         item,
  output logic           cmd_valid,
  output thc_pkg::cmd_t  cmd,
  input  logic           cmd_pop
);

  thc_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  thc_pkg::cmd_t cls;

  // fold the per-opcode payload into one operand
  always_comb begin
    cls.op   = item.opcode;
    cls.last = item.last;
    unique case (item.opcode)
      thc_pkg::OP_HEADER:  cls.operand = item.tick_number;
      thc_pkg::OP_DATA:    cls.operand = {56'd0, item.data_byte};
      thc_pkg::OP_COMPARE: cls.operand = item.other_hash;
      thc_pkg::OP_RESTART: begin
        cls.operand = 64'd0;
        cls.last    = 1'b0;
      end
    endcase
  end

  assign item.ready = (fill != 2'd2);
  assign push       = item.valid && item.ready;
  assign cmd_valid  = (fill != 2'd0);
  assign cmd        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= cls;
        wr_ptr    <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, cmd_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sv/thc_back.sv */
// thc_back: executes queued commands, holds the chain, history ram and result register
// depends on thc_pkg, thc_out_if and thc_ram
module thc_back #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [63:0]    seed,
  input  logic           cmd_valid,
  input  thc_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  thc_out_if.source      result
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state;
  logic [2:0]       byte_idx;
  logic             op_last;
  logic [63:0]      operand;
  logic [63:0]      chain_hash;
  logic [63:0]      tick_reg;
  logic [CNT_W-1:0] history_count;
  logic             overflow_flag;
  logic [CNT_W-1:0] cmp_idx;
  logic             mm_found;
  logic [63:0]      mm_tick;
  logic             res_done;
  logic             res_div;
  logic [63:0]      res_div_tick;

  logic [7:0]       mix_in;
  logic [63:0]      hash_mixed;
  logic             commit_now;
  logic             has_room;
  logic             ram_we;
  logic [127:0]     rdata;
  logic             mismatch;
  logic             found_new;
  logic [63:0]      tick_new;
  logic             emit;

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  // result register loads in the emit step when it is empty or being drained this cycle
  assign emit = (state == S_EMIT) && (!result.valid || result.ready);

  // one shared mixer: header bytes from tick_reg, data byte from the command
  assign mix_in     = (state == S_HDR) ? tick_reg[byte_idx*8 +: 8] : cmd.operand[7:0];
  assign hash_mixed = thc_pkg::mix_byte(chain_hash, mix_in);

  assign has_room   = history_count < DEPTH_C;
  assign commit_now = (cmd_pop && cmd.op == thc_pkg::OP_DATA && cmd.last) ||
                      (state == S_HDR && byte_idx == 3'd7 && op_last);
  assign ram_we     = commit_now && has_room;

  thc_ram #(.WIDTH(128), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (history_count[AW-1:0]),
    .wdata ({tick_reg, hash_mixed}),
    .raddr (cmp_idx[AW-1:0]),
    .rdata (rdata)
  );

  // entry beyond own history is ignored; only the first mismatch counts
  assign mismatch  = (cmp_idx < history_count) && !mm_found && (rdata[63:0] != operand);
  assign found_new = mm_found || mismatch;
  assign tick_new  = mismatch ? rdata[127:64] : mm_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_idx      <= 3'd0;
      chain_hash    <= thc_pkg::FNV_BASIS;
      tick_reg      <= 64'd0;
      history_count <= '0;
      overflow_flag <= 1'b0;
      cmp_idx       <= '0;
      mm_found      <= 1'b0;
      mm_tick       <= 64'd0;
      result.valid  <= 1'b0;
    end else begin
      if (!emit && result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (commit_now) begin
        if (has_room) begin
          history_count <= history_count + 1'b1;
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_last      <= cmd.last;
            operand      <= cmd.operand;
            res_done     <= 1'b0;
            res_div      <= 1'b0;
            res_div_tick <= 64'd0;
            unique case (cmd.op)
              thc_pkg::OP_RESTART: begin
                chain_hash    <= thc_pkg::FNV_BASIS ^ seed;
                tick_reg      <= 64'd0;
                history_count <= '0;
                overflow_flag <= 1'b0;
                cmp_idx       <= '0;
                mm_found      <= 1'b0;
                mm_tick       <= 64'd0;
                state         <= S_EMIT;
              end
              thc_pkg::OP_HEADER: begin
                tick_reg <= cmd.operand;
                byte_idx <= 3'd0;
                state    <= S_HDR;
              end
              thc_pkg::OP_DATA: begin
                chain_hash <= hash_mixed;
                state      <= S_EMIT;
              end
              thc_pkg::OP_COMPARE: begin
                state <= S_CMP;
              end
            endcase
          end
        end
        S_HDR: begin
          chain_hash <= hash_mixed;
          byte_idx   <= byte_idx + 3'd1;
          if (byte_idx == 3'd7) begin
            state <= S_EMIT;
          end
        end
        S_CMP: begin
          if (op_last) begin
            res_done     <= 1'b1;
            res_div      <= found_new;
            res_div_tick <= found_new ? tick_new : 64'd0;
            cmp_idx      <= '0;
            mm_found     <= 1'b0;
            mm_tick      <= 64'd0;
          end else begin
            mm_found <= found_new;
            mm_tick  <= tick_new;
            if (cmp_idx < DEPTH_C) begin
              cmp_idx <= cmp_idx + 1'b1;
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            result.valid            <= 1'b1;
            result.running_hash     <= chain_hash;
            result.current_tick     <= tick_reg;
            result.entries_stored   <= history_count;
            result.history_overflow <= overflow_flag;
            result.compare_done     <= res_done;
            result.diverged         <= res_div;
            result.divergence_tick  <= res_div_tick;
            state                   <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    history_count <= DEPTH_C) else $error("history count beyond depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> history_count == DEPTH_C) else $error("overflow without full history");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> history_count < DEPTH_C) else $error("history write when full");

  a_cmp_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmp_idx <= DEPTH_C) else $error("compare index beyond depth");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state != S_IDLE) else $error("popped command not executed");

endmodule

/* sv/tick_hash_chain_with_divergence.sv */
// tick_hash_chain_with_divergence: top level, seed register, front/back wiring
// depends on thc_pkg, thc_if, thc_front, thc_back, thc_ram
//
// channel  | dir | transaction
// ---------+-----+--------------------------------------------------------
// item     | in  | opcode, tick_number, data_byte, last, other_hash
// result   | out | running_hash, current_tick, entries_stored, flags, tick
// cfg      | in  | seed write, always ready
//
// restart and data items go from idle to emit in the back end, compares
// via a compare step (ram read), headers via byte mixes, one per cycle
// the front queues up to two items, so input is taken while a result waits
// rst is synchronous; history ram is not cleared, the entry count masks it
// result stalls hold the back end in its emit step only
module tick_hash_chain_with_divergence #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  thc_in_if.sink    item,
  thc_out_if.source result,
  thc_cfg_if.sink   cfg
);

  logic [63:0]   seed;
  logic          cmd_valid;
  thc_pkg::cmd_t cmd;
  logic          cmd_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (cfg.valid && cfg.ready) begin
      seed <= cfg.seed;
    end
  end

  thc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  thc_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .result    (result)
  );

endmodule
